// ===== design/pq3_pkg.sv =====
`default_nettype none

package pq3_pkg;

   localparam int VALUE_W = 32;
   localparam int LEVEL_W = 2;
   localparam int STATUS_W = 2;
   localparam int NUM_LEVELS = 3;

   typedef logic [LEVEL_W-1:0] level_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam status_type ST_INSERTED = 2'd0;
   localparam status_type ST_REMOVED = 2'd1;
   localparam status_type ST_FULL = 2'd2;
   localparam status_type ST_EMPTY = 2'd3;

   localparam level_type LEVEL_NONE = 2'd0;
   localparam level_type LEVEL_HIGH = 2'd1;
   localparam level_type LEVEL_MID = 2'd2;

   // per-transaction decision handed from pointer logic to the datapath
   typedef struct packed {
      status_type status;
      level_type level;
      logic rd_en;
      logic wr_en;
   } ctrl_type;

endpackage

`default_nettype wire

// ===== design/pq3_req_if.sv =====
`default_nettype none

interface pq3_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic signed [31:0] item_value;
   logic [1:0] level;

   modport source (output valid, output opcode, output item_value, output level,
                   input ready);
   modport sink (input valid, input opcode, input item_value, input level,
                 output ready);
endinterface

`default_nettype wire

// ===== design/pq3_rsp_if.sv =====
`default_nettype none

interface pq3_rsp_if;
   logic valid;
   logic ready;
   logic [1:0] status;
   logic signed [31:0] removed_value;
   logic [1:0] removed_level;

   modport source (output valid, output status, output removed_value,
                   output removed_level, input ready);
   modport sink (input valid, input status, input removed_value,
                 input removed_level, output ready);
endinterface

`default_nettype wire

// ===== design/pq3_store.sv =====
`default_nettype none

module pq3_store #(
   parameter int LEVEL_DEPTH = 16
) (
   input wire logic clock,
   input wire logic wr_en,
   input wire logic rd_en,
   input wire logic [$clog2(3 * LEVEL_DEPTH)-1:0] addr,
   input wire pq3_pkg::value_type wr_data,
   output pq3_pkg::value_type rd_data
);
   import pq3_pkg::*;

   localparam int TOTAL = NUM_LEVELS * LEVEL_DEPTH;

   value_type mem [TOTAL];
   value_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/pq3_ptr.sv =====
`default_nettype none

module pq3_ptr #(
   parameter int LEVEL_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic accept,
   input wire logic opcode,
   input wire pq3_pkg::level_type level,
   output pq3_pkg::ctrl_type ctrl,
   output logic [$clog2(3 * LEVEL_DEPTH)-1:0] addr
);
   import pq3_pkg::*;

   localparam int IDX_W = $clog2(LEVEL_DEPTH);
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);

   logic [IDX_W-1:0] head_ff [NUM_LEVELS];
   logic [IDX_W-1:0] head_in [NUM_LEVELS];
   logic [CNT_W-1:0] fill_ff [NUM_LEVELS];
   logic [CNT_W-1:0] fill_in [NUM_LEVELS];

   logic [1:0] sel;
   logic [SUM_W-1:0] sum;
   logic [IDX_W-1:0] tail;
   logic [ADDR_W-1:0] base;

   // queue picked by the insert level, or by priority on a remove
   always_comb begin
      if (opcode == OP_INSERT) begin
         if (level == LEVEL_HIGH) begin
            sel = 2'd0;
         end else if (level == LEVEL_MID) begin
            sel = 2'd1;
         end else begin
            sel = 2'd2;
         end
      end else begin
         if (fill_ff[0] != '0) begin
            sel = 2'd0;
         end else if (fill_ff[1] != '0) begin
            sel = 2'd1;
         end else begin
            sel = 2'd2;
         end
      end
   end

   // start of the ring for the selected level
   always_comb begin
      base = ADDR_W'(sel) * ADDR_W'(LEVEL_DEPTH);
   end

   // tail = (head + fill) mod depth, sum stays below twice the depth
   always_comb begin
      sum = SUM_W'(head_ff[sel]) + SUM_W'(fill_ff[sel]);
      if (sum >= SUM_W'(LEVEL_DEPTH)) begin
         tail = IDX_W'(sum - SUM_W'(LEVEL_DEPTH));
      end else begin
         tail = IDX_W'(sum);
      end
   end

   always_comb begin
      ctrl = '0;
      addr = '0;
      head_in = head_ff;
      fill_in = fill_ff;
      if (opcode == OP_INSERT) begin
         if (fill_ff[sel] == CNT_W'(LEVEL_DEPTH)) begin
            ctrl.status = ST_FULL;
         end else begin
            ctrl.status = ST_INSERTED;
            ctrl.wr_en = 1'b1;
            addr = base + ADDR_W'(tail);
            fill_in[sel] = fill_ff[sel] + CNT_W'(1);
         end
      end else if (fill_ff[sel] == '0) begin
         ctrl.status = ST_EMPTY;
      end else begin
         ctrl.status = ST_REMOVED;
         ctrl.rd_en = 1'b1;
         ctrl.level = level_type'(sel) + level_type'(1);
         addr = base + ADDR_W'(head_ff[sel]);
         if (head_ff[sel] == IDX_W'(LEVEL_DEPTH - 1)) begin
            head_in[sel] = '0;
         end else begin
            head_in[sel] = head_ff[sel] + IDX_W'(1);
         end
         fill_in[sel] = fill_ff[sel] - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else if (accept) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/three_level_priority_queue_unit.sv =====
// three-level strict priority queue
// req_if carries one transaction per operation: opcode 0 inserts item_value
// into the ring of its level (1 highest, 2 next, any other code is level 3),
// opcode 1 removes the oldest value of the highest non-empty level
// rsp_if returns exactly one transaction per request with status, the
// removed value and its level (value and level zero unless a remove hit)
// an accepted request goes through the read stage, then the response register
// behind rsp_if.valid; a receiver stall can hold it. throughput: one request
// per cycle while rsp keeps up; head and fill pointers update at the accept
// edge, the value ring sits in a single-port memory with a registered read,
// so the next request always sees the updated pointers and data
// a full insert is dropped with status full, a remove on empty queues
// reports status empty, neither changes any state
// reset (synchronous, active high) empties all three queues and drops any
// transaction in flight; the memory itself is not cleared
// when the receiver stalls, the response register holds and one more result
// waits in the read stage; after that req_if.ready drops until rsp moves
`default_nettype none

module three_level_priority_queue_unit #(
   parameter int LEVEL_DEPTH = 16
) (
   input wire logic clock,
   input wire logic reset,
   pq3_req_if.sink req_if,
   pq3_rsp_if.source rsp_if
);
   import pq3_pkg::*;

   localparam int ADDR_W = $clog2(NUM_LEVELS * LEVEL_DEPTH);

   ctrl_type ctrl;
   logic [ADDR_W-1:0] addr;
   logic accept;
   value_type rd_data;

   // read stage: decision registered alongside the memory read
   logic s1_valid_ff;
   status_type s1_status_ff;
   level_type s1_level_ff;
   logic s1_move;

   // response register
   logic rsp_valid_ff;
   status_type rsp_status_ff;
   value_type rsp_value_ff;
   level_type rsp_level_ff;

   assign s1_move = s1_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = !s1_valid_ff || s1_move;
   assign accept = req_if.valid && req_if.ready;

   // pointer bookkeeping and level selection
   pq3_ptr #(
      .LEVEL_DEPTH(LEVEL_DEPTH)
   ) u_ptr (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .opcode(req_if.opcode),
      .level(req_if.level),
      .ctrl(ctrl),
      .addr(addr)
   );

   // value rings, written on insert and read on remove at the accept edge
   pq3_store #(
      .LEVEL_DEPTH(LEVEL_DEPTH)
   ) u_store (
      .clock(clock),
      .wr_en(accept && ctrl.wr_en),
      .rd_en(accept && ctrl.rd_en),
      .addr(addr),
      .wr_data(req_if.item_value),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= ctrl.status;
         s1_level_ff <= ctrl.level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // read data only counts on a successful remove
   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_status_ff <= s1_status_ff;
         rsp_level_ff <= s1_level_ff;
         if (s1_status_ff == ST_REMOVED) begin
            rsp_value_ff <= rd_data;
         end else begin
            rsp_value_ff <= '0;
         end
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.status = rsp_status_ff;
   assign rsp_if.removed_value = rsp_value_ff;
   assign rsp_if.removed_level = rsp_level_ff;

   // a remove always reports where the value came from
   a_removed_has_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_REMOVED |-> rsp_level_ff != LEVEL_NONE)
      else $error("removed response without a level");

   // anything but a remove carries zero value and level
   a_other_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_REMOVED
      |-> rsp_value_ff == '0 && rsp_level_ff == LEVEL_NONE)
      else $error("non-remove response with payload");

   // a held read stage blocks new requests so read data is never overwritten
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_move |-> !req_if.ready)
      else $error("request taken while read stage is stuck");

   // reset drops everything in flight
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("transaction survived reset");

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import pq3_pkg::*;

   localparam int LEVEL_DEPTH = 16;
   localparam int IDLE_LIMIT = 500;      // cycles with no transaction on either side
   localparam int LONG_HOLD = 60;        // receiver back-pressure stretch

   // one response transaction as the block reports it
   typedef struct packed {
      status_type status;
      value_type value;
      level_type level;
   } pq_result_type;

   // one row of the directed table; fixed rows carry their own expectation
   typedef struct packed {
      logic op;
      value_type value;
      level_type lvl;
      bit fixed;
      pq_result_type res;
   } pq_row_type;

   localparam pq_result_type RES_INSERTED = '{ST_INSERTED, '0, LEVEL_NONE};
   localparam pq_result_type RES_EMPTY = '{ST_EMPTY, '0, LEVEL_NONE};
   localparam pq_result_type RES_PREDICTED = '0;

   localparam value_type V_MAX = 32'sh7fffffff;
   localparam value_type V_MIN = 32'sh80000000;

   localparam int NUM_ROWS = 19;
   localparam pq_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      // remove straight after reset: all queues empty
      '{OP_REMOVE, '0, LEVEL_NONE, 1'b1, RES_EMPTY},
      // extreme and patterned values into every level, level code 0 lands in level 3
      '{OP_INSERT, V_MAX, 2'd3, 1'b1, RES_INSERTED},
      '{OP_INSERT, V_MIN, LEVEL_MID, 1'b1, RES_INSERTED},
      '{OP_INSERT, -32'sd1, LEVEL_HIGH, 1'b1, RES_INSERTED},
      '{OP_INSERT, '0, LEVEL_NONE, 1'b1, RES_INSERTED},
      '{OP_INSERT, 32'sh55555555, LEVEL_HIGH, 1'b1, RES_INSERTED},
      '{OP_INSERT, 32'shaaaaaaaa, LEVEL_MID, 1'b1, RES_INSERTED},
      // drain in strict priority order, fifo order within a level
      '{OP_REMOVE, V_MAX, 2'd3, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, V_MIN, LEVEL_NONE, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, 32'sh55555555, LEVEL_MID, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, 32'shaaaaaaaa, LEVEL_HIGH, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, -32'sd1, 2'd3, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, '0, LEVEL_NONE, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, V_MAX, LEVEL_HIGH, 1'b1, RES_EMPTY},
      // a low-level value is overtaken by a later high-level one
      '{OP_INSERT, 32'sd12345, 2'd3, 1'b1, RES_INSERTED},
      '{OP_INSERT, -32'sd777, LEVEL_HIGH, 1'b1, RES_INSERTED},
      '{OP_REMOVE, '0, LEVEL_NONE, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, '0, LEVEL_NONE, 1'b0, RES_PREDICTED},
      '{OP_REMOVE, '0, LEVEL_NONE, 1'b1, RES_EMPTY}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pq3_req_if req ();
   pq3_rsp_if rsp ();

   three_level_priority_queue_unit #(
      .LEVEL_DEPTH(LEVEL_DEPTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req),
      .rsp_if(rsp)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow copy of the three rings
   value_type ring_data [NUM_LEVELS][LEVEL_DEPTH];
   int ring_head [NUM_LEVELS] = '{default: 0};
   int ring_fill [NUM_LEVELS] = '{default: 0};

   pq_result_type pending_results [$];
   int error_count = 0;
   int idle_cycles = 0;
   bit no_gaps = 1'b0;       // both sides run without idling
   bit hold_rsp = 1'b0;      // asks the receiver for one long stall

   // applies one accepted request to the shadow rings and returns its response
   function automatic pq_result_type pq_apply_op(logic op, value_type value, level_type lvl);
      int q;
      pq_result_type r;
      r = RES_INSERTED;
      if (op == OP_INSERT) begin
         // level codes other than high and mid all map to the lowest queue
         q = (lvl == LEVEL_HIGH) ? 0 : (lvl == LEVEL_MID) ? 1 : 2;
         if (ring_fill[q] == LEVEL_DEPTH) begin
            r.status = ST_FULL;
         end else begin
            ring_data[q][(ring_head[q] + ring_fill[q]) % LEVEL_DEPTH] = value;
            ring_fill[q]++;
         end
         return r;
      end
      // remove: first non-empty level wins
      r.status = ST_EMPTY;
      for (q = 0; q < NUM_LEVELS; q++) begin
         if (ring_fill[q] != 0) begin
            r.status = ST_REMOVED;
            r.value = ring_data[q][ring_head[q]];
            r.level = level_type'(q + 1);
            ring_head[q] = (ring_head[q] + 1) % LEVEL_DEPTH;
            ring_fill[q]--;
            return r;
         end
      end
      return r;
   endfunction

   // value mix weighted toward the extremes and simple patterns
   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0: return V_MAX;
         1: return V_MIN;
         2: return '0;
         3: return -32'sd1;
         default: return value_type'($urandom);
      endcase
   endfunction

   // offers one request transaction; entered and left at a falling edge
   task automatic send_op(input logic op, input value_type value, input level_type lvl,
                          input bit fixed, input pq_result_type fixed_res);
      int gap;
      pq_result_type res;
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.opcode <= op;
      req.item_value <= value;
      req.level <= lvl;
      do @(posedge clock); while (!req.ready);
      // shadow state always advances, fixed rows only override the expectation
      res = pq_apply_op(op, value, lvl);
      pending_results.push_back(fixed ? fixed_res : res);
      @(negedge clock);
   endtask

   // sender goes quiet until every outstanding response has come back
   task automatic wait_drained();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // random traffic: ins_pct sets the insert share, focus pins all inserts to one level
   task automatic send_random(input int count, input int ins_pct, input bit focus);
      level_type focus_lvl;
      logic op;
      focus_lvl = level_type'($urandom_range(0, 3));
      repeat (count) begin
         op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
         send_op(op, pick_value(), focus ? focus_lvl : level_type'($urandom_range(0, 3)),
                 1'b0, RES_PREDICTED);
      end
   endtask

   // response receiver with random back-pressure, one long stall on request
   initial begin : receiver
      int stall;
      rsp.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 10);
         if (hold_rsp) begin
            stall = LONG_HOLD;
            hold_rsp = 1'b0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
         @(negedge clock);
      end
   end

   // response checker: every accepted transaction against the oldest expectation
   always @(posedge clock) begin : rsp_check
      pq_result_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected response transaction: status=%0d value=%0d level=%0d",
                   rsp.status, rsp.removed_value, rsp.removed_level);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp.status);
               error_count++;
            end
            if (rsp.removed_value !== want.value) begin
               $error("removed_value: expected %0d, got %0d", want.value, rsp.removed_value);
               error_count++;
            end
            if (rsp.removed_level !== want.level) begin
               $error("removed_level: expected %0d, got %0d", want.level, rsp.removed_level);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles where neither side moves a transaction
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int ph;
      int ins_pct [8];
      ins_pct = '{50, 85, 15, 90, 50, 10, 70, 50};
      req.valid = 1'b0;
      req.opcode = OP_INSERT;
      req.item_value = '0;
      req.level = LEVEL_NONE;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < NUM_ROWS; i++) begin
         send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].lvl,
                 DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);
      end
      wait_drained();

      // long receiver stall while the sender keeps pushing back to back,
      // so both response stages fill and the block drops req ready
      hold_rsp = 1'b1;
      no_gaps = 1'b1;
      send_random(40, 70, 1'b0);
      no_gaps = 1'b0;
      wait_drained();

      // random phases: balanced, fill-heavy (full rejects), drain-heavy
      // (empty removes), some without any idling, some on a single level
      for (ph = 0; ph < 8; ph++) begin
         no_gaps = (ph % 3 == 2);
         send_random(100, ins_pct[ph], (ph == 3) || (ph == 6));
         if (ph % 2 == 1) wait_drained();
      end
      no_gaps = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/pq3_pkg.sv
design/pq3_req_if.sv
design/pq3_rsp_if.sv
design/pq3_store.sv
design/pq3_ptr.sv
design/three_level_priority_queue_unit.sv
test/tb_top.sv
